FILE: hw/rtl/chacha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_pkg
// Types, constants and helpers shared by the ChaCha20 keystream modules.
// ----------------------------------------------------------------------------
package chacha_pkg;

    localparam int BLOCK_BYTES   = 64;
    localparam int WORD_BITS     = 32;
    localparam int WORDS         = BLOCK_BYTES / 4;
    localparam int ROWS          = 4;
    localparam int COLS          = WORDS / ROWS;
    localparam int WORD_AW       = $clog2(WORDS);
    localparam int POS_W         = $clog2(BLOCK_BYTES) + 1;
    localparam int DOUBLE_ROUNDS = 10;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef word_t [WORDS-1:0]    block_t;

    localparam word_t SIGMA_0 = 32'h6170_7865;
    localparam word_t SIGMA_1 = 32'h3320_646e;
    localparam word_t SIGMA_2 = 32'h7962_2d32;
    localparam word_t SIGMA_3 = 32'h6b20_6574;

    // the four add-xor-rotate steps of one quarter round
    localparam logic [1:0] STEP_AD16 = 2'd0;
    localparam logic [1:0] STEP_CB12 = 2'd1;
    localparam logic [1:0] STEP_AD8  = 2'd2;
    localparam logic [1:0] STEP_CB7  = 2'd3;

    localparam int ROT_16 = 16;
    localparam int ROT_12 = 12;
    localparam int ROT_8  = 8;
    localparam int ROT_7  = 7;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef struct packed {
        logic               en;
        logic [WORD_AW-1:0] addr;
        word_t              data;
    } buf_wr_t;

    function automatic word_t rotl(input word_t v, input int unsigned n);
        rotl = (v << n) | (v >> (WORD_BITS - n));
    endfunction

endpackage

FILE: hw/rtl/chacha20_keystream_xor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_keystream_xor
// Byte-wide ChaCha20 keystream XOR with an APB register port.
//
//  channel   signals                               direction
//  in        in_valid, in_stall, data_byte         byte in, stall out
//  out       out_valid, out_stall, out_byte        byte out, stall in
//  cfg       psel, penable, pwrite, paddr, pwdata, register access
//            prdata, pready
//
// a byte served from the buffer is read into the buffer's read register
// on acceptance and XORed into the output register in the read state
// a byte that finds the buffer empty waits for a new block: 320
// quarter-round steps and 16 final adds on the one shared adder, then a buffer fetch and a read
// reset leaves the buffer empty and the counter at zero
// a stalled result holds in the output register; a new byte is taken only
// once the last one is read and that register is free or being emptied
// ----------------------------------------------------------------------------
module chacha20_keystream_xor
    import chacha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_GEN   = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    localparam logic [2:0] REG_KEY01  = 3'd0;
    localparam logic [2:0] REG_KEY23  = 3'd1;
    localparam logic [2:0] REG_KEY45  = 3'd2;
    localparam logic [2:0] REG_KEY67  = 3'd3;
    localparam logic [2:0] REG_NONCE01 = 3'd4;
    localparam logic [2:0] REG_NONCE2 = 3'd5;
    localparam logic [2:0] REG_START  = 3'd6;

    localparam logic [POS_W-1:0] POS_EMPTY = POS_W'(BLOCK_BYTES);

    logic [63:0] key01_reg, key23_reg, key45_reg, key67_reg, nonce01_reg;
    word_t       nonce2_reg, start_ctr_reg;

    logic [1:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    word_t            ctr_reg, ctr_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg;
    logic [7:0]       out_byte_reg;

    logic       cfg_we, cfg_hit, in_accept, core_start, rd_en;
    logic [2:0] cfg_idx;
    logic [7:0] ks_byte;

    block_t     init_words;
    core_stat_t core_stat;
    buf_wr_t    buf_wr;
    word_t      rd_word;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];
    assign cfg_hit = cfg_we && (cfg_idx inside {[REG_KEY01:REG_START]});

    always_comb
    begin
        case (cfg_idx)
            REG_KEY01:   prdata = key01_reg;
            REG_KEY23:   prdata = key23_reg;
            REG_KEY45:   prdata = key45_reg;
            REG_KEY67:   prdata = key67_reg;
            REG_NONCE01: prdata = nonce01_reg;
            REG_NONCE2:  prdata = {32'd0, nonce2_reg};
            REG_START:   prdata = {32'd0, start_ctr_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key01_reg     <= '0;
            key23_reg     <= '0;
            key45_reg     <= '0;
            key67_reg     <= '0;
            nonce01_reg   <= '0;
            nonce2_reg    <= '0;
            start_ctr_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_KEY01:   key01_reg     <= pwdata;
                REG_KEY23:   key23_reg     <= pwdata;
                REG_KEY45:   key45_reg     <= pwdata;
                REG_KEY67:   key67_reg     <= pwdata;
                REG_NONCE01: nonce01_reg   <= pwdata;
                REG_NONCE2:  nonce2_reg    <= pwdata[31:0];
                REG_START:   start_ctr_reg <= pwdata[31:0];
                default:     ;
            endcase
        end
    end

    assign init_words[0]  = SIGMA_0;
    assign init_words[1]  = SIGMA_1;
    assign init_words[2]  = SIGMA_2;
    assign init_words[3]  = SIGMA_3;
    assign init_words[4]  = key01_reg[31:0];
    assign init_words[5]  = key01_reg[63:32];
    assign init_words[6]  = key23_reg[31:0];
    assign init_words[7]  = key23_reg[63:32];
    assign init_words[8]  = key45_reg[31:0];
    assign init_words[9]  = key45_reg[63:32];
    assign init_words[10] = key67_reg[31:0];
    assign init_words[11] = key67_reg[63:32];
    assign init_words[12] = ctr_reg;
    assign init_words[13] = nonce01_reg[31:0];
    assign init_words[14] = nonce01_reg[63:32];
    assign init_words[15] = nonce2_reg;

    // the output register is free at the same edge it is emptied
    assign in_stall   = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign in_accept  = in_valid && !in_stall;
    assign core_start = in_accept && (pos_reg == POS_EMPTY);
    assign rd_en      = (in_accept && !core_start) || (state_reg == ST_FETCH);
    assign ks_byte    = rd_word[{pos_reg[1:0], 3'b000} +: 8];

    chacha_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (core_start),
        .init_words (init_words),
        .stat       (core_stat),
        .buf_wr     (buf_wr)
    );

    chacha_ks_buffer u_buf (
        .clk     (clk),
        .wr      (buf_wr),
        .rd_en   (rd_en),
        .rd_addr (pos_reg[WORD_AW+1:2]),
        .rd_data (rd_word)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        ctr_next       = ctr_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (core_start)
                    state_next = ST_GEN;
                else if (in_accept)
                    state_next = ST_READ;
            end
            ST_GEN:
            begin
                if (core_stat.done)
                begin
                    state_next = ST_FETCH;
                    pos_next   = '0;
                    ctr_next   = ctr_reg + 32'd1;
                end
            end
            ST_FETCH:
                state_next = ST_READ;
            ST_READ:
            begin
                state_next     = ST_IDLE;
                pos_next       = pos_reg + POS_W'(1);
                out_valid_next = 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase
        // any register write reseeks to the start counter
        if (cfg_hit)
        begin
            pos_next = POS_EMPTY;
            ctr_next = (cfg_idx == REG_START) ? pwdata[31:0] : start_ctr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POS_EMPTY;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            byte_reg <= data_byte;
        if (state_reg == ST_READ)
            out_byte_reg <= byte_reg ^ ks_byte;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

`ifndef SYNTH
    a_done_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |=> (pos_reg == '0) && (ctr_reg == $past(ctr_reg) + 32'd1))
        else $error("block finish did not rewind position and bump counter");

    a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GEN) |-> core_stat.busy)
        else $error("waiting on a block while the core is idle");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !out_valid_reg)
        else $error("result produced while output register still full");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_EMPTY)
        else $error("buffer position beyond block end");

    a_start_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        core_start |-> !core_stat.busy && (state_reg == ST_IDLE))
        else $error("block started while core busy");
`endif

endmodule

FILE: hw/rtl/chacha_qr_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_qr_unit
// Shared add, xor and rotate unit: one quarter-round step per use.
// ----------------------------------------------------------------------------
module chacha_qr_unit
    import chacha_pkg::*;
(
    input  word_t      x,
    input  word_t      y,
    input  word_t      z,
    input  logic [1:0] step,
    output word_t      s,
    output word_t      t
);

    word_t mix;

    assign s   = x + y;
    assign mix = z ^ s;

    always_comb
    begin
        case (step)
            STEP_AD16: t = rotl(mix, ROT_16);
            STEP_CB12: t = rotl(mix, ROT_12);
            STEP_AD8:  t = rotl(mix, ROT_8);
            STEP_CB7:  t = rotl(mix, ROT_7);
            default:   t = mix;
        endcase
    end

endmodule

FILE: hw/rtl/chacha_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_core
// Block function sequencer: 320 quarter-round steps then 16 final adds,
// all through one shared unit, writing the block word by word.
// ----------------------------------------------------------------------------
module chacha_core
    import chacha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  block_t     init_words,
    output core_stat_t stat,
    output buf_wr_t    buf_wr
);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_ROUND = 2'd1;
    localparam logic [1:0] C_ADD   = 2'd2;

    localparam int DR_W = $clog2(DOUBLE_ROUNDS);

    localparam logic [2:0] QR_LAST_COL  = 3'd3;
    localparam logic [2:0] QR_LAST_DIAG = 3'd7;

    // the unit always works on column zero of the four rows
    localparam logic [WORD_AW-1:0] A_POS = WORD_AW'(0);
    localparam logic [WORD_AW-1:0] B_POS = WORD_AW'(COLS);
    localparam logic [WORD_AW-1:0] C_POS = WORD_AW'(2 * COLS);
    localparam logic [WORD_AW-1:0] D_POS = WORD_AW'(3 * COLS);

    logic [1:0]         state_reg, state_next;
    logic [1:0]         step_reg, step_next;
    logic [2:0]         qr_reg, qr_next;
    logic [DR_W-1:0]    dr_reg, dr_next;
    logic [WORD_AW-1:0] add_idx_reg, add_idx_next;

    word_t work_reg  [WORDS];
    word_t work_next [WORDS];
    word_t upd       [WORDS];
    logic [1:0] rk   [ROWS];

    word_t ux, uy, uz, us, ut;
    logic  add_last;

    chacha_qr_unit u_unit (
        .x    (ux),
        .y    (uy),
        .z    (uz),
        .step (step_reg),
        .s    (us),
        .t    (ut)
    );

    assign add_last = (state_reg == C_ADD) && (add_idx_reg == WORD_AW'(WORDS - 1));

    always_comb
    begin
        if (state_reg == C_ADD)
        begin
            ux = work_reg[A_POS];
            uy = init_words[add_idx_reg];
            uz = '0;
        end
        else if (step_reg[0])
        begin
            ux = work_reg[C_POS];
            uy = work_reg[D_POS];
            uz = work_reg[B_POS];
        end
        else
        begin
            ux = work_reg[A_POS];
            uy = work_reg[B_POS];
            uz = work_reg[D_POS];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        qr_next      = qr_reg;
        dr_next      = dr_reg;
        add_idx_next = add_idx_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_ROUND;
                    step_next  = STEP_AD16;
                    qr_next    = '0;
                    dr_next    = '0;
                end
            end
            C_ROUND:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == STEP_CB7)
                begin
                    qr_next = qr_reg + 3'd1;
                    if (qr_reg == QR_LAST_DIAG)
                    begin
                        dr_next = dr_reg + DR_W'(1);
                        if (dr_reg == DR_W'(DOUBLE_ROUNDS - 1))
                        begin
                            state_next   = C_ADD;
                            add_idx_next = '0;
                        end
                    end
                end
            end
            C_ADD:
            begin
                add_idx_next = add_idx_reg + WORD_AW'(1);
                if (add_last)
                    state_next = C_IDLE;
            end
            default:
                state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        upd = work_reg;
        if (state_reg == C_ROUND)
        begin
            if (!step_reg[0])
            begin
                upd[A_POS] = us;
                upd[D_POS] = ut;
            end
            else
            begin
                upd[C_POS] = us;
                upd[B_POS] = ut;
            end
        end

        // after each quarter round the rows turn by one word; at the end of
        // the column half they also diagonalise, at the end of the diagonal
        // half they turn back
        for (int r = 0; r < ROWS; r++)
        begin
            rk[r] = 2'd0;
            if ((state_reg == C_ROUND) && (step_reg == STEP_CB7))
            begin
                if (qr_reg == QR_LAST_COL)
                    rk[r] = 2'(r + 1);
                else if (qr_reg == QR_LAST_DIAG)
                    rk[r] = 2'(1 - r);
                else
                    rk[r] = 2'd1;
            end
        end

        for (int r = 0; r < ROWS; r++)
        begin
            for (int j = 0; j < COLS; j++)
            begin
                work_next[r * COLS + j] = upd[{2'(r), 2'(2'(j) + rk[r])}];
            end
        end

        if (state_reg == C_ADD)
        begin
            for (int j = 0; j < WORDS - 1; j++)
                work_next[j] = work_reg[j + 1];
            work_next[WORDS-1] = work_reg[WORDS-1];
        end
        else if ((state_reg == C_IDLE) && start)
        begin
            for (int j = 0; j < WORDS; j++)
                work_next[j] = init_words[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            step_reg    <= STEP_AD16;
            qr_reg      <= '0;
            dr_reg      <= '0;
            add_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            qr_reg      <= qr_next;
            dr_reg      <= dr_next;
            add_idx_reg <= add_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < WORDS; j++)
            work_reg[j] <= work_next[j];
    end

    assign stat.busy   = (state_reg != C_IDLE);
    assign stat.done   = add_last;
    assign buf_wr.en   = (state_reg == C_ADD);
    assign buf_wr.addr = add_idx_reg;
    assign buf_wr.data = us;

endmodule

FILE: hw/rtl/chacha_ks_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_ks_buffer
// Keystream block store: one word written and one word read per cycle, each while its enable is set.
// ----------------------------------------------------------------------------
module chacha_ks_buffer
    import chacha_pkg::*;
(
    input  logic               clk,
    input  buf_wr_t            wr,
    input  logic               rd_en,
    input  logic [WORD_AW-1:0] rd_addr,
    output word_t              rd_data
);

    word_t mem [WORDS];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
